/* design/tsp_pkg.sv */
// Shared types, constants and lookup functions of the time string parser.
package tsp_pkg;

	localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [62:0] HOUR_LIMIT = 63'(MAX63 / 64'd3600);
	localparam logic [16:0] DAY_SECONDS = 17'd86400;
	localparam logic [29:0] NSEC_PER_SEC = 30'd1000000000;
	localparam logic [29:0] NSEC_MAX = 30'd999999999;
	// floor(2^45 / 86400) + 1; exact quotient for dividends below 2^26.
	localparam logic [28:0] DAY_RECIP = 29'd407226529;
	localparam int DAY_RECIP_SHIFT = 45;

	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_5 = 8'h35;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_U = 8'h55;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [2:0] WORD_LEN = 3'd7;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_SYNTAX = 2'd1;
	localparam status_t ST_RANGE = 2'd2;
	localparam status_t ST_PAST = 2'd3;

	typedef enum logic [10:0] {
		PH_START      = 11'b000_0000_0001,
		PH_HOUR_FIRST = 11'b000_0000_0010,
		PH_HOUR       = 11'b000_0000_0100,
		PH_MIN_FIRST  = 11'b000_0000_1000,
		PH_MIN        = 11'b000_0001_0000,
		PH_SEC_FIRST  = 11'b000_0010_0000,
		PH_SEC        = 11'b000_0100_0000,
		PH_TAIL       = 11'b000_1000_0000,
		PH_FRAC       = 11'b001_0000_0000,
		PH_SUFFIX     = 11'b010_0000_0000,
		PH_DONE       = 11'b100_0000_0000
	} phase_t;

	typedef enum logic [6:0] {
		SUF_NONE  = 7'b000_0001,
		SUF_SPACE = 7'b000_0010,
		SUF_Z     = 7'b000_0100,
		SUF_U     = 7'b000_1000,
		SUF_UT    = 7'b001_0000,
		SUF_UTC   = 7'b010_0000,
		SUF_BAD   = 7'b100_0000
	} suffix_t;

	typedef struct packed {
		phase_t      phase;
		logic        rel;
		logic        clock;
		logic [62:0] main;
		logic [62:0] minute;
		logic [62:0] second;
		logic [29:0] frac;
		logic [3:0]  digits;
		logic        round_up;
		status_t     err;
		logic [2:0]  word_idx;
		logic        word_miss;
		suffix_t     suffix;
		logic        ovf;
		logic        colon;
		status_t     verdict;
	} lex_state_t;

	localparam lex_state_t LEX_IDLE = '{
		phase: PH_START, rel: 1'b0, clock: 1'b0, main: 63'd0, minute: 63'd0,
		second: 63'd0, frac: 30'd0, digits: 4'd0, round_up: 1'b0, err: ST_OK,
		word_idx: 3'd0, word_miss: 1'b0, suffix: SUF_NONE, ovf: 1'b0,
		colon: 1'b0, verdict: ST_OK
	};

	// UTF-8 bytes of the word meaning "tomorrow".
	function automatic logic [7:0] word_byte(input logic [2:0] idx);
		case (idx)
			3'd0: word_byte = 8'h6D;
			3'd1: word_byte = 8'h61;
			3'd2: word_byte = 8'hC3;
			3'd3: word_byte = 8'hB1;
			3'd4: word_byte = 8'h61;
			3'd5: word_byte = 8'h6E;
			3'd6: word_byte = 8'h61;
			default: word_byte = 8'h00;
		endcase
	endfunction

	// Scale that brings a fraction of the given digit count to nanoseconds.
	function automatic logic [29:0] pow10_fill(input logic [3:0] digits);
		case (digits)
			4'd0: pow10_fill = 30'd1000000000;
			4'd1: pow10_fill = 30'd100000000;
			4'd2: pow10_fill = 30'd10000000;
			4'd3: pow10_fill = 30'd1000000;
			4'd4: pow10_fill = 30'd100000;
			4'd5: pow10_fill = 30'd10000;
			4'd6: pow10_fill = 30'd1000;
			4'd7: pow10_fill = 30'd100;
			4'd8: pow10_fill = 30'd10;
			default: pow10_fill = 30'd1;
		endcase
	endfunction

	// 2^(8*j) mod 86400, the weight of byte j of a second count.
	function automatic logic [16:0] day_chunk_weight(input logic [2:0] j);
		case (j)
			3'd0: day_chunk_weight = 17'd1;
			3'd1: day_chunk_weight = 17'd256;
			3'd2: day_chunk_weight = 17'd65536;
			3'd3: day_chunk_weight = 17'd15616;
			3'd4: day_chunk_weight = 17'd23296;
			3'd5: day_chunk_weight = 17'd2176;
			3'd6: day_chunk_weight = 17'd38656;
			default: day_chunk_weight = 17'd46336;
		endcase
	endfunction

endpackage

/* design/tsp_in_if.sv */
// Input channel: one string byte with its last mark and the clock readings.
interface tsp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  char_byte;
	logic        last_byte;
	logic [62:0] now_real_sec;
	logic [29:0] now_real_nsec;
	logic [62:0] now_boot_sec;
	logic [29:0] now_boot_nsec;

	modport source (output valid, char_byte, last_byte, now_real_sec, now_real_nsec,
		now_boot_sec, now_boot_nsec, input ready);
	modport sink (input valid, char_byte, last_byte, now_real_sec, now_real_nsec,
		now_boot_sec, now_boot_nsec, output ready);
endinterface

/* design/tsp_out_if.sv */
// Output channel: one parsed wake-up time with status and warnings.
interface tsp_out_if;
	logic        valid;
	logic        ready;
	logic [62:0] result_sec;
	logic [29:0] result_nsec;
	logic        clock_kind;
	logic [1:0]  status;
	logic        warn_no_utc;
	logic        warn_moved_tomorrow;

	modport source (output valid, result_sec, result_nsec, clock_kind, status,
		warn_no_utc, warn_moved_tomorrow, input ready);
	modport sink (input valid, result_sec, result_nsec, clock_kind, status,
		warn_no_utc, warn_moved_tomorrow, output ready);
endinterface

/* design/tsp_lexer.sv */
// Per-byte parse state machine; presents the state after the current byte.
module tsp_lexer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          char_byte,
	input  logic                last_byte,
	input  logic                take,
	output tsp_pkg::lex_state_t snap
);

	tsp_pkg::lex_state_t st_q, st_d;
	logic              is_dig;
	logic [3:0]        dv;
	logic [7:0]        up;
	logic [66:0]       acc_main, acc_min, acc_sec;
	logic [63:0]       min_sum, sec_sum;
	logic              do_tail, feed;
	tsp_pkg::phase_t   tph;

	assign is_dig = char_byte inside {[tsp_pkg::CH_0:tsp_pkg::CH_9]};
	assign dv = char_byte[3:0];
	assign up = (char_byte inside {[tsp_pkg::CH_LA:tsp_pkg::CH_LZ]}) ?
		char_byte - 8'd32 : char_byte;
	assign acc_main = {4'b0, st_q.main} * 67'd10 + 67'(dv);
	assign acc_min = {4'b0, st_q.minute} * 67'd10 + 67'(dv);
	assign acc_sec = {4'b0, st_q.second} * 67'd10 + 67'(dv);
	assign min_sum = {1'b0, st_q.main} + 64'(st_q.minute[5:0]) * 64'd60;
	assign sec_sum = {1'b0, st_q.main} + {1'b0, st_q.second};

	always_comb begin
		st_d = st_q;
		do_tail = 1'b0;
		feed = 1'b0;
		tph = st_q.phase;

		if (!st_q.word_miss) begin
			if (st_q.word_idx != tsp_pkg::WORD_LEN &&
				char_byte == tsp_pkg::word_byte(st_q.word_idx)) begin
				st_d.word_idx = st_q.word_idx + 3'd1;
			end else begin
				st_d.word_miss = 1'b1;
			end
		end

		case (st_q.phase)
			tsp_pkg::PH_START, tsp_pkg::PH_HOUR_FIRST: begin
				if (st_q.phase == tsp_pkg::PH_START && char_byte == tsp_pkg::CH_PLUS) begin
					st_d.rel = 1'b1;
					st_d.phase = tsp_pkg::PH_HOUR_FIRST;
				end else if (is_dig) begin
					st_d.main = 63'(dv);
					st_d.ovf = 1'b0;
					st_d.phase = tsp_pkg::PH_HOUR;
				end else begin
					st_d.err = tsp_pkg::ST_SYNTAX;
					st_d.phase = tsp_pkg::PH_DONE;
				end
			end
			tsp_pkg::PH_HOUR: begin
				if (is_dig) begin
					if (acc_main > 67'(tsp_pkg::MAX63)) st_d.ovf = 1'b1;
					else st_d.main = acc_main[62:0];
				end else if (st_q.ovf) begin
					st_d.err = tsp_pkg::ST_RANGE;
					st_d.phase = tsp_pkg::PH_DONE;
				end else if (char_byte == tsp_pkg::CH_COLON) begin
					if (st_q.main > tsp_pkg::HOUR_LIMIT) begin
						st_d.err = tsp_pkg::ST_RANGE;
						st_d.phase = tsp_pkg::PH_DONE;
					end else begin
						st_d.main = 63'(st_q.main * 63'd3600);
						st_d.clock = 1'b1;
						st_d.phase = tsp_pkg::PH_MIN_FIRST;
					end
				end else begin
					// A second count ended; a colon seen later still decides the answer.
					st_d.verdict = (st_q.main > tsp_pkg::HOUR_LIMIT) ?
						tsp_pkg::ST_RANGE : tsp_pkg::ST_SYNTAX;
					st_d.phase = tsp_pkg::PH_TAIL;
					tph = tsp_pkg::PH_TAIL;
					do_tail = 1'b1;
				end
			end
			tsp_pkg::PH_MIN_FIRST, tsp_pkg::PH_SEC_FIRST: begin
				if (!is_dig) begin
					st_d.err = tsp_pkg::ST_SYNTAX;
					st_d.phase = tsp_pkg::PH_DONE;
				end else if (st_q.phase == tsp_pkg::PH_MIN_FIRST) begin
					st_d.minute = 63'(dv);
					st_d.ovf = 1'b0;
					st_d.phase = tsp_pkg::PH_MIN;
				end else begin
					st_d.second = 63'(dv);
					st_d.ovf = 1'b0;
					st_d.phase = tsp_pkg::PH_SEC;
				end
			end
			tsp_pkg::PH_MIN: begin
				if (is_dig) begin
					if (acc_min > 67'(tsp_pkg::MAX63)) st_d.ovf = 1'b1;
					else st_d.minute = acc_min[62:0];
				end else if (st_q.ovf) begin
					st_d.err = tsp_pkg::ST_RANGE;
					st_d.phase = tsp_pkg::PH_DONE;
				end else if (st_q.minute >= 63'd60) begin
					st_d.err = tsp_pkg::ST_SYNTAX;
					st_d.phase = tsp_pkg::PH_DONE;
				end else if (min_sum[63]) begin
					st_d.err = tsp_pkg::ST_RANGE;
					st_d.phase = tsp_pkg::PH_DONE;
				end else begin
					st_d.main = min_sum[62:0];
					if (char_byte == tsp_pkg::CH_COLON) begin
						st_d.phase = tsp_pkg::PH_SEC_FIRST;
					end else begin
						st_d.phase = tsp_pkg::PH_TAIL;
						tph = tsp_pkg::PH_TAIL;
						do_tail = 1'b1;
					end
				end
			end
			tsp_pkg::PH_SEC: begin
				if (is_dig) begin
					if (acc_sec > 67'(tsp_pkg::MAX63)) st_d.ovf = 1'b1;
					else st_d.second = acc_sec[62:0];
				end else if (st_q.ovf || sec_sum[63]) begin
					st_d.err = tsp_pkg::ST_RANGE;
					st_d.phase = tsp_pkg::PH_DONE;
				end else begin
					st_d.main = sec_sum[62:0];
					st_d.phase = tsp_pkg::PH_TAIL;
					tph = tsp_pkg::PH_TAIL;
					do_tail = 1'b1;
				end
			end
			tsp_pkg::PH_TAIL, tsp_pkg::PH_FRAC, tsp_pkg::PH_SUFFIX: begin
				do_tail = 1'b1;
			end
			default: ;
		endcase

		if (do_tail) begin
			if (!st_q.clock && char_byte == tsp_pkg::CH_COLON) st_d.colon = 1'b1;
			case (tph)
				tsp_pkg::PH_TAIL: begin
					if (char_byte == tsp_pkg::CH_DOT) begin
						st_d.phase = tsp_pkg::PH_FRAC;
					end else begin
						st_d.phase = tsp_pkg::PH_SUFFIX;
						feed = 1'b1;
					end
				end
				tsp_pkg::PH_FRAC: begin
					if (is_dig) begin
						if (st_q.digits < 4'd9) begin
							st_d.frac = 30'(st_q.frac * 30'd10) + 30'(dv);
							st_d.digits = st_q.digits + 4'd1;
						end else if (st_q.digits == 4'd9) begin
							// The tenth digit only rounds; later digits are dropped.
							if (char_byte >= tsp_pkg::CH_5) st_d.round_up = 1'b1;
							st_d.digits = 4'd10;
						end
					end else begin
						st_d.phase = tsp_pkg::PH_SUFFIX;
						feed = 1'b1;
					end
				end
				default: feed = 1'b1;
			endcase
		end

		if (feed) begin
			case (st_q.suffix)
				tsp_pkg::SUF_NONE, tsp_pkg::SUF_SPACE: begin
					if (up == tsp_pkg::CH_SPACE) st_d.suffix = tsp_pkg::SUF_SPACE;
					else if (up == tsp_pkg::CH_Z) st_d.suffix = tsp_pkg::SUF_Z;
					else if (up == tsp_pkg::CH_U) st_d.suffix = tsp_pkg::SUF_U;
					else st_d.suffix = tsp_pkg::SUF_BAD;
				end
				tsp_pkg::SUF_U: st_d.suffix = (up == tsp_pkg::CH_T) ?
					tsp_pkg::SUF_UT : tsp_pkg::SUF_BAD;
				tsp_pkg::SUF_UT: st_d.suffix = (up == tsp_pkg::CH_C) ?
					tsp_pkg::SUF_UTC : tsp_pkg::SUF_BAD;
				default: st_d.suffix = tsp_pkg::SUF_BAD;
			endcase
		end
	end

	assign snap = st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tsp_pkg::LEX_IDLE;
		end else if (take) begin
			st_q <= last_byte ? tsp_pkg::LEX_IDLE : st_d;
		end
	end

endmodule

/* design/time_string_parser_core.sv */
// Top level: byte parser, five-stage time resolution pipeline and output register.
//
// Usage: bytes of a time string arrive on req, one transaction per byte, with
// last_byte set on the final byte; the clock readings are sampled only with
// that final byte. Each string yields exactly one transaction on rsp.
// Throughput: one byte per cycle while req.ready is high, set by the per-byte digit accumulate
// (multiply by ten, add and range compare on a 63-bit value).
// After the last byte is accepted, its result passes the stages for end of
// number, day divide by reciprocal, midnight, base sum and final day or boot
// clock adjustment, then the output register, which presents it on rsp.
// A new string may start in the cycle after a last byte.
// Reset clears the parse state and every stage valid; no clearing pass.
// When rsp stalls, results wait in the output register and the pipeline
// closes its bubbles; req.ready falls only once all five stages and the
// output register hold results.
module time_string_parser_core (
	input logic       clk,
	input logic       arst_n,
	tsp_in_if.sink    req,
	tsp_out_if.source rsp
);

	typedef struct packed {
		logic                 rel;
		logic                 clock;
		logic                 word;
		logic                 colon;
		tsp_pkg::status_t     err;
		tsp_pkg::status_t     verdict;
		tsp_pkg::suffix_t     suffix;
		logic [62:0]          main;
		logic [62:0]          cs;
		logic [62:0]          rs;
		logic [29:0]          rn;
		logic [62:0]          bs;
		logic [29:0]          bn;
	} carry_t;

	logic en_out, en5, en4, en3, en2, en1;
	logic take;

	tsp_pkg::lex_state_t snap;
	tsp_pkg::lex_state_t lx_s1;
	logic [62:0] rs_s1, bs_s1;
	logic [29:0] rn_s1, bn_s1;
	logic        v_s1;

	carry_t      cr_s2, cr_s3, cr_s4, cr_s5;
	logic [25:0] r1_s2, r1_s3;
	logic [29:0] n1_s2, n2_s3, n2_s4, n2_s5;
	logic [9:0]  q_s3;
	logic        carry_s3, carry_s4;
	logic [62:0] midnight_s4;
	logic [62:0] s_s5;
	logic        ovf_s5;
	logic        v_s2, v_s3, v_s4, v_s5;

	logic        out_valid_q;
	logic [62:0] sec_q;
	logic [29:0] nsec_q;
	logic        kind_q, no_utc_q, moved_q;
	tsp_pkg::status_t status_q;

	assign en_out = !out_valid_q || rsp.ready;
	assign en5 = !v_s5 || en_out;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;
	assign take = req.valid && en1;

	tsp_lexer u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_byte(req.char_byte),
		.last_byte(req.last_byte),
		.take     (take),
		.snap     (snap)
	);

	// Stage 1: close the number in progress, start the day remainder and
	// scale the fraction.
	carry_t      cr1;
	logic [63:0] min_sum1, sec_sum1;
	logic [25:0] r1;
	logic [29:0] n1;
	logic [7:0]  chunk;

	assign min_sum1 = {1'b0, lx_s1.main} + 64'(lx_s1.minute[5:0]) * 64'd60;
	assign sec_sum1 = {1'b0, lx_s1.main} + {1'b0, lx_s1.second};
	assign n1 = 30'(lx_s1.frac * tsp_pkg::pow10_fill(lx_s1.digits)) + 30'(lx_s1.round_up);

	always_comb begin
		cr1.rel = lx_s1.rel;
		cr1.clock = lx_s1.clock;
		cr1.word = (lx_s1.word_idx == tsp_pkg::WORD_LEN) && !lx_s1.word_miss;
		cr1.colon = lx_s1.colon;
		cr1.err = lx_s1.err;
		cr1.verdict = lx_s1.verdict;
		cr1.suffix = lx_s1.suffix;
		cr1.main = lx_s1.main;
		cr1.cs = lx_s1.rel ? bs_s1 : rs_s1;
		cr1.rs = rs_s1;
		cr1.rn = rn_s1;
		cr1.bs = bs_s1;
		cr1.bn = bn_s1;
		case (lx_s1.phase)
			tsp_pkg::PH_HOUR_FIRST, tsp_pkg::PH_MIN_FIRST, tsp_pkg::PH_SEC_FIRST:
				cr1.err = tsp_pkg::ST_SYNTAX;
			tsp_pkg::PH_HOUR: begin
				if (lx_s1.ovf) cr1.err = tsp_pkg::ST_RANGE;
				else cr1.verdict = (lx_s1.main > tsp_pkg::HOUR_LIMIT) ?
					tsp_pkg::ST_RANGE : tsp_pkg::ST_SYNTAX;
			end
			tsp_pkg::PH_MIN: begin
				if (lx_s1.ovf) cr1.err = tsp_pkg::ST_RANGE;
				else if (lx_s1.minute >= 63'd60) cr1.err = tsp_pkg::ST_SYNTAX;
				else if (min_sum1[63]) cr1.err = tsp_pkg::ST_RANGE;
				else cr1.main = min_sum1[62:0];
			end
			tsp_pkg::PH_SEC: begin
				if (lx_s1.ovf || sec_sum1[63]) cr1.err = tsp_pkg::ST_RANGE;
				else cr1.main = sec_sum1[62:0];
			end
			default: ;
		endcase

		// Each byte of the base clock contributes its weight modulo one day.
		r1 = '0;
		for (int j = 0; j < 8; j++) begin
			chunk = 8'(cr1.cs >> (8 * j));
			r1 = r1 + 26'(chunk * tsp_pkg::day_chunk_weight(3'(j)));
		end
	end

	// Stage 2: quotient of the folded remainder by one day; fraction carry.
	logic [54:0] recip_prod;
	logic [9:0]  q2;
	logic        carry2;
	logic [29:0] n2;

	assign recip_prod = 55'(r1_s2) * 55'(tsp_pkg::DAY_RECIP);
	assign q2 = 10'(recip_prod >> tsp_pkg::DAY_RECIP_SHIFT);
	assign carry2 = n1_s2 >= tsp_pkg::NSEC_PER_SEC;
	assign n2 = carry2 ? n1_s2 - tsp_pkg::NSEC_PER_SEC : n1_s2;

	// Stage 3: seconds since midnight and the midnight itself.
	logic [25:0] rem3;
	logic [62:0] midnight3;

	assign rem3 = r1_s3 - 26'(27'(q_s3) * 27'(tsp_pkg::DAY_SECONDS));
	assign midnight3 = cr_s3.cs - 63'(rem3);

	// Stage 4: base sum with the midnight and the fraction carry.
	logic [63:0] sum4;

	assign sum4 = {1'b0, cr_s4.main} + (cr_s4.clock ? {1'b0, midnight_s4} : 64'd0) +
		64'(carry_s4);

	// Stage 5: boot clock sum, the day adjustment or the word's time a day ahead, and the status.
	logic [30:0] t5;
	logic        c5;
	logic [63:0] boot5, day5, word5;
	logic [62:0] sec5;
	logic [29:0] nsec5;
	logic        kind5, no_utc5, moved5;
	tsp_pkg::status_t status5;

	assign t5 = 31'(n2_s5) + 31'(cr_s5.bn);
	assign c5 = t5 >= 31'(tsp_pkg::NSEC_PER_SEC);
	assign boot5 = {1'b0, s_s5} + {1'b0, cr_s5.bs} + 64'(c5);
	assign day5 = {1'b0, s_s5} + 64'(tsp_pkg::DAY_SECONDS);
	assign word5 = {1'b0, cr_s5.rs} + 64'(tsp_pkg::DAY_SECONDS);

	always_comb begin
		sec5 = s_s5;
		nsec5 = n2_s5;
		moved5 = 1'b0;
		no_utc5 = 1'b0;
		kind5 = cr_s5.rel;
		status5 = tsp_pkg::ST_OK;
		if (cr_s5.word) begin
			kind5 = 1'b0;
			sec5 = word5[62:0];
			nsec5 = cr_s5.rn;
			status5 = word5[63] ? tsp_pkg::ST_RANGE : tsp_pkg::ST_OK;
		end else begin
			no_utc5 = !cr_s5.rel && cr_s5.suffix == tsp_pkg::SUF_NONE;
			if (!cr_s5.clock && cr_s5.colon) begin
				status5 = cr_s5.verdict;
			end else if (cr_s5.err != tsp_pkg::ST_OK) begin
				status5 = cr_s5.err;
			end else if (ovf_s5) begin
				status5 = tsp_pkg::ST_RANGE;
			end else if (cr_s5.suffix != tsp_pkg::SUF_NONE && (cr_s5.rel ||
				(cr_s5.suffix != tsp_pkg::SUF_Z && cr_s5.suffix != tsp_pkg::SUF_UTC))) begin
				status5 = tsp_pkg::ST_SYNTAX;
			end else if (cr_s5.rel) begin
				if (boot5[63]) status5 = tsp_pkg::ST_RANGE;
				sec5 = boot5[62:0];
				nsec5 = c5 ? 30'(t5 - 31'(tsp_pkg::NSEC_PER_SEC)) : t5[29:0];
			end else if (s_s5 < cr_s5.rs) begin
				// Past times move one day ahead; still past means too far back.
				if (day5[63]) status5 = tsp_pkg::ST_RANGE;
				else if (day5[62:0] < cr_s5.rs) status5 = tsp_pkg::ST_PAST;
				sec5 = day5[62:0];
				moved5 = !cr_s5.clock;
			end
		end
		if (status5 != tsp_pkg::ST_OK) begin
			sec5 = '0;
			nsec5 = '0;
			moved5 = 1'b0;
			no_utc5 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= take && req.last_byte;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en_out) out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (take && req.last_byte) begin
			lx_s1 <= snap;
			rs_s1 <= req.now_real_sec;
			bs_s1 <= req.now_boot_sec;
			rn_s1 <= (req.now_real_nsec > tsp_pkg::NSEC_MAX) ?
				tsp_pkg::NSEC_MAX : req.now_real_nsec;
			bn_s1 <= (req.now_boot_nsec > tsp_pkg::NSEC_MAX) ?
				tsp_pkg::NSEC_MAX : req.now_boot_nsec;
		end
		if (en2) begin
			cr_s2 <= cr1;
			r1_s2 <= r1;
			n1_s2 <= n1;
		end
		if (en3) begin
			cr_s3 <= cr_s2;
			r1_s3 <= r1_s2;
			q_s3 <= q2;
			carry_s3 <= carry2;
			n2_s3 <= n2;
		end
		if (en4) begin
			cr_s4 <= cr_s3;
			carry_s4 <= carry_s3;
			n2_s4 <= n2_s3;
			midnight_s4 <= midnight3;
		end
		if (en5) begin
			cr_s5 <= cr_s4;
			n2_s5 <= n2_s4;
			s_s5 <= sum4[62:0];
			ovf_s5 <= sum4[63];
		end
		if (en_out && v_s5) begin
			sec_q <= sec5;
			nsec_q <= nsec5;
			kind_q <= kind5;
			status_q <= status5;
			no_utc_q <= no_utc5;
			moved_q <= moved5;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.result_sec = sec_q;
	assign rsp.result_nsec = nsec_q;
	assign rsp.clock_kind = kind_q;
	assign rsp.status = status_q;
	assign rsp.warn_no_utc = no_utc_q;
	assign rsp.warn_moved_tomorrow = moved_q;

	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != tsp_pkg::ST_OK |-> rsp.result_sec == '0 &&
			rsp.result_nsec == '0 && !rsp.warn_no_utc && !rsp.warn_moved_tomorrow)
		else $error("failed transaction carries a time or a warning");

	a_boot_no_warn: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.clock_kind |-> !rsp.warn_no_utc && !rsp.warn_moved_tomorrow)
		else $error("boot clock result carries a wall clock warning");

	a_nsec_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.result_nsec <= tsp_pkg::NSEC_MAX)
		else $error("nanosecond part out of range");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_valid_q)
		else $error("input stalled while the pipeline has a free stage");

	a_last_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.last_byte |=> v_s1)
		else $error("last byte did not enter the resolution pipeline");

endmodule
